@@ hdl/lurr_pkg.sv @@
// lurr_pkg: shared types and constants for the LU rank and reduced-matrix block.
// Payload structs, controller states, command and status groups.
// No dependencies.
`default_nettype none

package lurr_pkg;

  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam int ACC_W     = 56;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_VARIABLE  = 2'd0;
  localparam logic [1:0] ST_DEPENDENT = 2'd1;
  localparam logic [1:0] ST_FIXED     = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] entry_value;
  } lurr_in_t;

  typedef struct packed {
    logic signed [31:0] reduced_value;
    logic [1:0]         row_status;
    logic [5:0]         rank;
    logic               error;
  } lurr_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_RK_ISSUE,
    S_RK_CHECK,
    S_DECIDE,
    S_SC_ROW,
    S_SC_ISSUE,
    S_SC_CHECK,
    S_DOT_CHECK,
    S_DOT_LW,
    S_DOT_UW,
    S_DOT_ACC,
    S_DIAG_WAIT,
    S_FINISH
  } lurr_state_t;

  // read address source
  typedef enum logic [2:0] {
    ADDR_ITEM,
    ADDR_DIAG,
    ADDR_SCAN,
    ADDR_L,
    ADDR_U
  } lurr_addr_t;

  typedef struct packed {
    logic       capture;
    logic       mem_wr;
    logic       mem_rd;
    lurr_addr_t rd_sel;
    logic       i_inc;
    logic       i_load_rank;
    logic       rank_latch;
    logic       k_clr;
    logic       k_inc;
    logic       dep_set;
    logic       acc_clr;
    logic       l_load;
    logic       prod_load;
    logic       acc_prod;
    logic       acc_diag;
    logic       out_load;
  } lurr_cmd_t;

  typedef struct packed {
    logic is_read;
    logic rank_done;
    logic rdata_zero;
    logic row_ok;
    logic in_range;
    logic below_rank;
    logic past_row;
    logic col_done;
    logic dot_done;
    logic upper;
  } lurr_sts_t;

endpackage

`default_nettype wire

@@ hdl/lu_rank_and_reduced_matrix.sv @@
// lu_rank_and_reduced_matrix: top level of the packed-LU rank and reduced-entry block.
// Uses lurr_pkg, lurr_ctrl and lurr_dp (which holds lurr_ram).
//
//   port group  direction  handshake              payload
//   in_*        input      in_valid / in_stall    in_data   (lurr_in_t)
//   out_*       output     out_valid / out_stall  out_data  (lurr_out_t)
//   cfg_*       input      cfg_write              cfg_index, cfg_data
//
// Write item: decode, write, then finish. Read item: a rank search along the diagonal up to the first
// zero entry, then a row-status walk (row in range, at or past the rank) or a dot product (row below
// the rank, item in range) that also adds the stored entry for an upper entry; else it finishes.
// One item at a time; the next item is taken while a finished result waits in the output
// register, and it holds in its last cycle until that result is taken. rst_n is synchronous:
// counts return to 32, no result is pending; the store keeps its contents.
`default_nettype none

module lu_rank_and_reduced_matrix
  import lurr_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lurr_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lurr_out_t                 out_data,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data
);

  lurr_cmd_t cmd;
  lurr_sts_t sts;

  lurr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lurr_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

@@ hdl/lurr_ram.sv @@
// lurr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lurr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/lurr_ctrl.sv @@
// lurr_ctrl: sequencer for write, rank search, row scan and dot product.
// Uses lurr_pkg; drives lurr_dp through lurr_cmd_t, reads lurr_sts_t.
`default_nettype none

module lurr_ctrl
  import lurr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire lurr_sts_t sts,
  output lurr_cmd_t      cmd
);

  lurr_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = sts.is_read ? S_RK_ISSUE : S_WRITE;
      end
      S_WRITE: state_nxt = S_FINISH;
      S_RK_ISSUE: begin
        state_nxt = sts.rank_done ? S_DECIDE : S_RK_CHECK;
      end
      S_RK_CHECK: begin
        state_nxt = sts.rdata_zero ? S_DECIDE : S_RK_ISSUE;
      end
      S_DECIDE: begin
        if (sts.row_ok && !sts.below_rank) begin
          state_nxt = S_SC_ROW;
        end else if (sts.in_range && sts.below_rank) begin
          state_nxt = S_DOT_CHECK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SC_ROW: begin
        state_nxt = sts.past_row ? S_FINISH : S_SC_ISSUE;
      end
      S_SC_ISSUE: begin
        state_nxt = sts.col_done ? S_FINISH : S_SC_CHECK;
      end
      S_SC_CHECK: begin
        state_nxt = sts.rdata_zero ? S_SC_ISSUE : S_SC_ROW;
      end
      S_DOT_CHECK: begin
        if (!sts.dot_done) begin
          state_nxt = S_DOT_LW;
        end else begin
          state_nxt = sts.upper ? S_DIAG_WAIT : S_FINISH;
        end
      end
      S_DOT_LW:    state_nxt = S_DOT_UW;
      S_DOT_UW:    state_nxt = S_DOT_ACC;
      S_DOT_ACC:   state_nxt = S_DOT_CHECK;
      S_DIAG_WAIT: state_nxt = S_FINISH;
      S_FINISH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_WRITE: begin
        cmd.mem_wr = 1'b1;
      end
      S_RK_ISSUE: begin
        if (sts.rank_done) begin
          cmd.rank_latch = 1'b1;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = ADDR_DIAG;
        end
      end
      S_RK_CHECK: begin
        if (sts.rdata_zero) begin
          cmd.rank_latch = 1'b1;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_DECIDE: begin
        if (sts.row_ok && !sts.below_rank) begin
          cmd.i_load_rank = 1'b1;
        end else if (sts.in_range && sts.below_rank) begin
          cmd.k_clr   = 1'b1;
          cmd.acc_clr = 1'b1;
        end
      end
      S_SC_ROW: begin
        if (sts.past_row) begin
          cmd.dep_set = 1'b1;
        end else begin
          cmd.k_clr = 1'b1;
        end
      end
      S_SC_ISSUE: begin
        if (!sts.col_done) begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = ADDR_SCAN;
        end
      end
      S_SC_CHECK: begin
        if (sts.rdata_zero) begin
          cmd.k_inc = 1'b1;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_DOT_CHECK: begin
        if (!sts.dot_done) begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = ADDR_L;
        end else if (sts.upper) begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = ADDR_ITEM;
        end
      end
      S_DOT_LW: begin
        cmd.l_load = 1'b1;
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = ADDR_U;
      end
      S_DOT_UW: begin
        cmd.prod_load = 1'b1;
      end
      S_DOT_ACC: begin
        cmd.acc_prod = 1'b1;
        cmd.k_inc    = 1'b1;
      end
      S_DIAG_WAIT: begin
        cmd.acc_diag = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTH
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a waiting result");

  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write in the same cycle");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE))
    else $error("result load did not end the item");
`endif

endmodule

`default_nettype wire

@@ hdl/lurr_dp.sv @@
// lurr_dp: datapath with the LU store, counters, multiply-accumulate and result register.
// Uses lurr_pkg and lurr_ram; controlled by lurr_ctrl.
`default_nettype none

module lurr_dp
  import lurr_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data,
  input  wire lurr_in_t             in_data,
  output lurr_out_t                 out_data,
  input  wire lurr_cmd_t            cmd,
  output lurr_sts_t                 sts
);

  localparam int ERW    = $clog2(MAX_ROWS + 1);
  localparam int ECW    = $clog2(MAX_COLS + 1);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int SEL_W0 = (ERW > ECW) ? ERW : ECW;
  localparam int SEL_W  = (SEL_W0 > 5) ? SEL_W0 : 5;

  logic [COUNT_W-1:0] row_count_r, col_count_r;
  logic [ERW-1:0]     eff_rows;
  logic [ECW-1:0]     eff_cols;
  logic [SEL_W-1:0]   diag_lim;
  logic [5:0]         dot_lim;

  lurr_in_t           item_r;
  logic [ERW-1:0]     i_r;
  logic [ERW-1:0]     rank_r;
  logic [ECW-1:0]     k_r;
  logic               dep_r;
  logic signed [31:0] l_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  lurr_out_t          out_r;

  logic [SEL_W-1:0]   row_sel, col_sel;
  logic [AW-1:0]      rd_addr, item_addr;
  logic [31:0]        rdata;
  logic               err;
  logic signed [31:0] sat_val;
  logic [1:0]         status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= COUNT_RESET;
      col_count_r <= COUNT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_ROW_COUNT) row_count_r <= cfg_data;
      if (cfg_index == REG_COL_COUNT) col_count_r <= cfg_data;
    end
  end

  // counts above the array size act as the size
  always_comb begin
    eff_rows = (32'(row_count_r) > 32'(MAX_ROWS)) ? ERW'(MAX_ROWS) : ERW'(row_count_r);
    eff_cols = (32'(col_count_r) > 32'(MAX_COLS)) ? ECW'(MAX_COLS) : ECW'(col_count_r);
    diag_lim = (32'(eff_rows) < 32'(eff_cols)) ? SEL_W'(eff_rows) : SEL_W'(eff_cols);
    dot_lim  = ({1'b0, item_r.row} < ({1'b0, item_r.col} + 6'd1)) ?
               {1'b0, item_r.row} : ({1'b0, item_r.col} + 6'd1);
  end

  always_comb begin
    case (cmd.rd_sel)
      ADDR_DIAG: begin
        row_sel = SEL_W'(i_r);
        col_sel = SEL_W'(i_r);
      end
      ADDR_SCAN: begin
        row_sel = SEL_W'(i_r);
        col_sel = SEL_W'(k_r);
      end
      ADDR_L: begin
        row_sel = SEL_W'(item_r.row);
        col_sel = SEL_W'(k_r);
      end
      ADDR_U: begin
        row_sel = SEL_W'(k_r);
        col_sel = SEL_W'(item_r.col);
      end
      default: begin
        row_sel = SEL_W'(item_r.row);
        col_sel = SEL_W'(item_r.col);
      end
    endcase
    rd_addr   = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);
    item_addr = AW'(item_r.row) * AW'(MAX_COLS) + AW'(item_r.col);
  end

  lurr_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.mem_wr && sts.in_range),
    .wr_addr(item_addr),
    .wr_data(item_r.entry_value),
    .rd_en  (cmd.mem_rd),
    .rd_addr(rd_addr),
    .rd_data(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      i_r    <= '0;
      dep_r  <= 1'b0;
    end
    if (cmd.i_inc)       i_r    <= i_r + ERW'(1);
    if (cmd.i_load_rank) i_r    <= rank_r;
    if (cmd.rank_latch)  rank_r <= i_r;
    if (cmd.k_clr)       k_r    <= '0;
    if (cmd.k_inc)       k_r    <= k_r + ECW'(1);
    if (cmd.dep_set)     dep_r  <= 1'b1;
    if (cmd.l_load)      l_r    <= $signed(rdata);
    if (cmd.prod_load)   prod_r <= l_r * $signed(rdata);
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_prod) begin
      // round half up to Q16.16: floor((p + 2^15) / 2^16)
      acc_r <= acc_r + ACC_W'(prod_r >>> 16) + {{(ACC_W-1){1'b0}}, prod_r[15]};
    end else if (cmd.acc_diag) begin
      acc_r <= acc_r + ACC_W'($signed(rdata));
    end
    if (cmd.out_load)    out_r  <= '{reduced_value: (err || !sts.is_read) ? 32'sd0 : sat_val,
                                     row_status: status,
                                     rank: sts.is_read ? 6'(rank_r) : 6'd0,
                                     error: err};
  end

  always_comb begin
    sts.is_read    = (item_r.operation == OP_READ);
    sts.rank_done  = (32'(i_r) >= 32'(diag_lim));
    sts.rdata_zero = (rdata == '0);
    sts.row_ok     = (32'(item_r.row) < 32'(eff_rows));
    sts.in_range   = sts.row_ok && (32'(item_r.col) < 32'(eff_cols));
    sts.below_rank = (32'(item_r.row) < 32'(rank_r));
    sts.past_row   = (32'(i_r) > 32'(item_r.row));
    sts.col_done   = (32'(k_r) >= 32'(eff_cols));
    sts.dot_done   = (32'(k_r) >= 32'(dot_lim));
    sts.upper      = (item_r.row <= item_r.col);
  end

  always_comb begin
    if ((&acc_r[ACC_W-1:31]) || !(|acc_r[ACC_W-1:31])) begin
      sat_val = acc_r[31:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7FFF_FFFF;
    end
    err = sts.is_read ? (!sts.in_range || !sts.below_rank) : !sts.in_range;
    if (!sts.is_read || !sts.row_ok || sts.below_rank) begin
      status = ST_VARIABLE;
    end else begin
      status = dep_r ? ST_DEPENDENT : ST_FIXED;
    end
  end

  assign out_data = out_r;

`ifndef SYNTH
  a_rd_in_array: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |-> (32'(row_sel) < 32'(MAX_ROWS)) && (32'(col_sel) < 32'(MAX_COLS)))
    else $error("read outside the stored array");

  a_rank_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.rank_latch) |-> (32'(rank_r) <= 32'(diag_lim)))
    else $error("rank above the smaller dimension");

  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.out_load) |-> (!out_r.error || out_r.reduced_value == 32'sd0))
    else $error("error result with nonzero value");
`endif

endmodule

`default_nettype wire
